>>> rtl/isort_pkg.sv
// Shared constants and types for the insertion sorter.
`default_nettype none

package isort_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0]        count_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic ins;       // insert the broadcast word this cycle
        logic drain;     // shift the row down by one place
        logic occupied;  // cell holds a live entry
        logic tail;      // cell is the first free place
    } cell_ctrl_t;

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

endpackage

`default_nettype wire

>>> rtl/isort_cell.sv
// One compare-and-shift cell of the sorting row.
`default_nettype none

module isort_cell (
    input  wire                   clk,
    input  isort_pkg::value_t     ins_value,
    input  isort_pkg::value_t     below_value,
    input  wire                   below_greater,
    input  isort_pkg::value_t     above_value,
    input  isort_pkg::cell_ctrl_t ctrl,
    output isort_pkg::value_t     stored,
    output logic                  greater
);
    import isort_pkg::*;

    value_t store_reg;
    value_t store_next;

    // Strictly greater keeps equal values in arrival order
    assign greater = ctrl.occupied && (store_reg > ins_value);
    assign stored  = store_reg;

    // Take from neighbor, take the new word, or hold
    always_comb
    begin
        store_next = store_reg;
        if (ctrl.drain)
        begin
            store_next = above_value;
        end
        else if (ctrl.ins)
        begin
            if (below_greater)
                store_next = below_value;
            else if (greater || ctrl.tail)
                store_next = ins_value;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

endmodule

`default_nettype wire

>>> rtl/insertion_sorter.sv
// Top level of the streaming insertion sorter.
`default_nettype none

// Insertion sorter: while not busy, one word is taken per cycle (start high)
// and inserted into a row of MAX_ELEMENTS compare-and-shift cells in that
// same cycle, so loading runs at one word per clock. The word carrying last
// is inserted too unless the row is full; then busy rises and the row
// drains one entry per cycle from its low end: a set of n stored entries
// yields n results, each marked by result_valid, in ascending signed order,
// with last_res on the final one. Words arriving while the row is full are
// dropped and overflow is set on every result of that set. The receiver
// cannot stall; results must be taken as they come.
// A new set may start the cycle after busy falls.
module insertion_sorter (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire signed [31:0]        value,
    input  wire                      last,
    output logic                     result_valid,
    output logic signed [31:0]       value_res,
    output logic                     last_res,
    output logic                     overflow
);
    import isort_pkg::*;

    logic   state_reg, state_next;
    count_t count_reg, count_next;
    logic   ovf_reg, ovf_next;
    logic   res_valid_reg;
    value_t res_value_reg;
    logic   res_last_reg;
    logic   res_ovf_reg;

    logic   accept;
    logic   full;
    logic   do_ins;
    logic   do_drain;

    value_t                 cell_val [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] cell_gt;

    assign busy     = (state_reg == ST_DRAIN);
    assign accept   = start && !busy;
    assign full     = (count_reg == count_t'(MAX_ELEMENTS));
    assign do_ins   = accept && !full;
    assign do_drain = busy;

    // Build the row of cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++)
        begin : g_cell
            cell_ctrl_t ctrl;
            value_t     below_v;
            logic       below_g;
            value_t     above_v;

            assign ctrl.ins      = do_ins;
            assign ctrl.drain    = do_drain;
            assign ctrl.occupied = (count_reg > count_t'(gi));
            assign ctrl.tail     = (count_reg == count_t'(gi));

            if (gi == 0)
            begin : g_first
                assign below_v = '0;
                assign below_g = 1'b0;
            end
            else
            begin : g_mid
                assign below_v = cell_val[gi-1];
                assign below_g = cell_gt[gi-1];
            end

            if (gi == MAX_ELEMENTS - 1)
            begin : g_top
                assign above_v = '0;
            end
            else
            begin : g_low
                assign above_v = cell_val[gi+1];
            end

            isort_cell u_cell (
                .clk           (clk),
                .ins_value     (value),
                .below_value   (below_v),
                .below_greater (below_g),
                .above_value   (above_v),
                .ctrl          (ctrl),
                .stored        (cell_val[gi]),
                .greater       (cell_gt[gi])
            );
        end
    endgenerate

    // Sequence loading and draining
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                        count_next = count_reg + count_t'(1);
                    if (last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                count_next = count_reg - count_t'(1);
                if (count_reg == count_t'(1))
                begin
                    state_next = ST_LOAD;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= do_drain;
        end
    end

    // Capture the low end of the row as the outgoing word
    always_ff @(posedge clk)
    begin
        if (do_drain)
        begin
            res_value_reg <= cell_val[0];
            res_last_reg  <= (count_reg == count_t'(1));
            res_ovf_reg   <= ovf_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign value_res    = res_value_reg;
    assign last_res     = res_last_reg;
    assign overflow     = res_ovf_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(MAX_ELEMENTS))
        else $error("entry count exceeds capacity");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg != '0))
        else $error("draining an empty row");

    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result word without a drain cycle");

    a_last_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_res) |-> (!busy && count_reg == '0 && !ovf_reg))
        else $error("set not cleared after final word");
`endif

endmodule

`default_nettype wire
